FILE: hdl/lrs_pkg.sv
// Package for the log ratio event sampler: field widths, fixed-point
// constants, register indexes and reset values.
// No dependencies.
package lrs_pkg;

    localparam int unsigned SampleW   = 16;   // Q2.13 sample fields
    localparam int unsigned AngErrW   = 15;   // angle error / dead band
    localparam int unsigned PosErrW   = 16;   // position error / dead band
    localparam int unsigned BaseW     = 16;   // ratio base, Q4.12
    localparam int unsigned BaseFracW = 12;   // fraction bits of the base
    localparam int unsigned CfgAddrW  = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned InDataW   = 48;
    localparam int unsigned OutDataW  = 8;

    localparam logic [SampleW:0]   PiQ13     = 17'd25736;  // pi in Q2.13
    localparam logic [BaseW-1:0]   BaseReset = 16'd8192;   // 2.0
    localparam logic [AngErrW-1:0] AngRefReset = 15'd1;
    localparam logic [PosErrW-1:0] PosRefReset = 16'd1;

    typedef enum logic [CfgAddrW-1:0] {
        REG_ANGLE_DEAD_BAND    = 2'd0,
        REG_POSITION_DEAD_BAND = 2'd1,
        REG_RATIO_BASE         = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic position_fired;
        logic angle_fired;
        logic take_sample;
    } t_result;

endpackage

FILE: hdl/log_ratio_event_sampler_top.sv
// Log ratio event sampler: registered trigger with two axes, input and result registers.
// Depends on lrs_pkg.
//
//  channel    dir   handshake          payload
//  i_s_*      in    tvalid/tready      tdata: cart_position, pole_angle,
//                                      target_position; tuser: target_down
//  o_m_*      out   tvalid/tready      tdata: take_sample, angle_fired,
//                                      position_fired
//  i_cfg_*    in    write enable only  index + 16 bit data, no read-back
//
// One request per cycle sustained while the output is not stalled; an accepted
// request is held in the input register, then its result is loaded into the
// result register. The references are updated at the same edge that loads the
// result, so the next request sees them at once. Synchronous active-low reset
// clears the valids and dead bands, sets the ratio base to 2.0 and the references
// to one. An output stall holds the result; the input register still takes a
// request while it is empty or the result register is free or draining.
module log_ratio_event_sampler_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] cart_position, [31:16] pole_angle, [47:32] target_position
    input  logic [lrs_pkg::InDataW-1:0]       i_s_tdata,
    // [0] target_down
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] take_sample, [1] angle_fired, [2] position_fired, [7:3] zero
    output logic [lrs_pkg::OutDataW-1:0]      o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [lrs_pkg::CfgAddrW-1:0]      i_cfg_addr,
    input  logic [lrs_pkg::CfgDataW-1:0]      i_cfg_wdata
);
    import lrs_pkg::*;

    logic [AngErrW-1:0]  r_angle_dead_band;
    logic [PosErrW-1:0]  r_position_dead_band;
    logic [BaseW-1:0]    r_ratio_base;
    logic [AngErrW-1:0]  r_angle_reference, n_angle_reference;
    logic [PosErrW-1:0]  r_position_reference, n_position_reference;

    logic                r_in_vld;
    logic [InDataW-1:0]  r_in_data;
    logic                r_in_down;
    logic                r_out_vld;
    t_result             r_result, n_result;

    logic                advance;

    logic signed [SampleW-1:0] cart_pos, pole_ang, tgt_pos;
    logic [SampleW:0]          ang_mag;
    logic [AngErrW-1:0]        ang_err;
    logic signed [SampleW:0]   pos_diff;
    logic [SampleW:0]          pos_abs;
    logic [PosErrW-1:0]        pos_err;
    logic                      ang_fire, pos_fire;

    // ratio test: err*1.0 >= base*ref or ref*1.0 >= base*err (Q4.12 base)
    function automatic logic ratio_hit(input logic [PosErrW-1:0] err,
                                       input logic [PosErrW-1:0] ref_v,
                                       input logic [BaseW-1:0]   base);
        logic [PosErrW+BaseW-1:0] e_sh, r_sh, b_r, b_e;
        begin
            e_sh = {{(BaseW-BaseFracW){1'b0}}, err, {BaseFracW{1'b0}}};
            r_sh = {{(BaseW-BaseFracW){1'b0}}, ref_v, {BaseFracW{1'b0}}};
            b_r  = base * ref_v;
            b_e  = base * err;
            ratio_hit = (e_sh >= b_r) || (r_sh >= b_e);
        end
    endfunction

    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;

    // error magnitudes
    always_comb begin
        cart_pos = r_in_data[SampleW-1:0];
        pole_ang = r_in_data[2*SampleW-1:SampleW];
        tgt_pos  = r_in_data[3*SampleW-1:2*SampleW];

        ang_mag = pole_ang[SampleW-1] ? (~{pole_ang[SampleW-1], pole_ang} + 1'b1)
                                      : {1'b0, pole_ang};
        if (r_in_down) begin
            // hanging target: clamp at zero past pi
            ang_err = (ang_mag >= PiQ13) ? '0 : AngErrW'(PiQ13 - ang_mag);
        end else begin
            ang_err = (ang_mag > {2'b00, {AngErrW{1'b1}}}) ? {AngErrW{1'b1}}
                                                           : ang_mag[AngErrW-1:0];
        end

        pos_diff = {cart_pos[SampleW-1], cart_pos} - {tgt_pos[SampleW-1], tgt_pos};
        pos_abs  = pos_diff[SampleW] ? (SampleW+1)'(-pos_diff)
                                     : pos_diff;
        pos_err  = pos_abs[PosErrW-1:0];
    end

    always_comb begin
        ang_fire = (ang_err > r_angle_dead_band) && (r_angle_reference != '0) &&
                   ratio_hit({1'b0, ang_err}, {1'b0, r_angle_reference}, r_ratio_base);
        pos_fire = (pos_err > r_position_dead_band) && (r_position_reference != '0) &&
                   ratio_hit(pos_err, r_position_reference, r_ratio_base);

        n_result.take_sample    = ang_fire || pos_fire;
        n_result.angle_fired    = ang_fire;
        n_result.position_fired = pos_fire;

        n_angle_reference    = ang_fire ? ang_err : r_angle_reference;
        n_position_reference = pos_fire ? pos_err : r_position_reference;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_dead_band    <= '0;
            r_position_dead_band <= '0;
            r_ratio_base         <= BaseReset;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_ANGLE_DEAD_BAND:    r_angle_dead_band    <= i_cfg_wdata[AngErrW-1:0];
                REG_POSITION_DEAD_BAND: r_position_dead_band <= i_cfg_wdata[PosErrW-1:0];
                REG_RATIO_BASE:         r_ratio_base         <= i_cfg_wdata[BaseW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
            r_in_down <= i_s_tuser;
        end
    end

    // result register and references
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld            <= 1'b0;
            r_angle_reference    <= AngRefReset;
            r_position_reference <= PosRefReset;
        end else begin
            if (advance) begin
                r_out_vld            <= 1'b1;
                r_angle_reference    <= n_angle_reference;
                r_position_reference <= n_position_reference;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OutDataW-3){1'b0}}, r_result.position_fired,
                         r_result.angle_fired, r_result.take_sample};

endmodule

FILE: tb/tb_top.sv
// Testbench for the log ratio event sampler: drives pendulum samples on the
// input stream, predicts the trigger flags and checks every result request.
// Depends on lrs_pkg and log_ratio_event_sampler_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrs_pkg::*;

    localparam int unsigned PI_Q13      = 25736;  // pi * 8192, rounded
    localparam int unsigned ONE_Q12     = 4096;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [CfgAddrW-1:0] REG_UNMAPPED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_we = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    // shadow of the block's registers and references
    logic [AngErrW-1:0]  angle_band = '0;
    logic [PosErrW-1:0]  position_band = '0;
    logic [BaseW-1:0]    base_q12 = BaseReset;
    logic [AngErrW-1:0]  angle_ref = 15'd1;
    logic [PosErrW-1:0]  position_ref = 16'd1;

    t_result pending_flags[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int errors = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int angle_fires = 0;
    int position_fires = 0;
    int cycle_count = 0;

    logic [15:0] last_pos = '0;
    logic [15:0] last_ang = '0;
    logic [15:0] last_tgt = '0;

    log_ratio_event_sampler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [15:0] pos, [31:16] angle, [47:32] target
        .i_s_tuser  (s_tuser),    // [0] target_down
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [0] take_sample, [1] angle, [2] position
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // error > band, and the error moved by at least the base factor either way
    function automatic logic crosses_ratio(int unsigned err, int unsigned band,
                                           int unsigned prior);
        longint unsigned e_scaled;
        longint unsigned p_scaled;
        if (err <= band || prior == 0)
            return 1'b0;
        e_scaled = longint'(err) * ONE_Q12;
        p_scaled = longint'(prior) * ONE_Q12;
        return (e_scaled >= longint'(base_q12) * prior) ||
               (p_scaled >= longint'(base_q12) * err);
    endfunction

    task automatic predict_trigger(input logic [InDataW-1:0] data, input logic down,
                                   output t_result flags);
        int pos;
        int ang;
        int tgt;
        int unsigned mag;
        int unsigned ang_err;
        int unsigned pos_err;
        pos = int'($signed(data[15:0]));
        ang = int'($signed(data[31:16]));
        tgt = int'($signed(data[47:32]));
        mag = (ang < 0) ? -ang : ang;
        if (down)
            ang_err = (mag >= PI_Q13) ? 0 : PI_Q13 - mag;
        else
            ang_err = mag;
        if (ang_err > 32767)
            ang_err = 32767;
        pos_err = (pos - tgt < 0) ? tgt - pos : pos - tgt;
        flags.angle_fired    = crosses_ratio(ang_err, angle_band, angle_ref);
        flags.position_fired = crosses_ratio(pos_err, position_band, position_ref);
        flags.take_sample    = flags.angle_fired | flags.position_fired;
        if (flags.angle_fired)
            angle_ref = ang_err[AngErrW-1:0];
        if (flags.position_fired)
            position_ref = pos_err[PosErrW-1:0];
    endtask

    // input side: predict on every accepted request
    always @(posedge i_clk) begin
        t_result flags;
        if (i_rst_n && s_tvalid && s_tready) begin
            predict_trigger(s_tdata, s_tuser, flags);
            pending_flags.push_back(flags);
        end
    end

    // output side: compare against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_flags.size() == 0) begin
                $error("result 0x%02h with no request outstanding", m_tdata);
                errors++;
            end else begin
                want = pending_flags.pop_front();
                if (m_tdata[0] !== want.take_sample) begin
                    $error("take_sample: expected %0b, got %0b", want.take_sample, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[1] !== want.angle_fired) begin
                    $error("angle_fired: expected %0b, got %0b", want.angle_fired, m_tdata[1]);
                    errors++;
                end
                if (m_tdata[2] !== want.position_fired) begin
                    $error("position_fired: expected %0b, got %0b",
                           want.position_fired, m_tdata[2]);
                    errors++;
                end
                if (m_tdata[7:3] !== 5'd0) begin
                    $error("padding: expected 0, got %0h", m_tdata[7:3]);
                    errors++;
                end
                if (want.angle_fired)
                    angle_fires++;
                if (want.position_fired)
                    position_fires++;
            end
        end
    end

    task automatic send_sample(input int pos, input int ang, input int tgt, input bit down);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt[15:0], ang[15:0], pos[15:0]};
        s_tuser  <= down;
        last_pos = pos[15:0];
        last_ang = ang[15:0];
        last_tgt = tgt[15:0];
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        samples_sent++;
    endtask

    // block idle: no result outstanding, plus a margin for its input and result registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_flags.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_DEAD_BAND:    angle_band = val[AngErrW-1:0];
            REG_POSITION_DEAD_BAND: position_band = val;
            REG_RATIO_BASE:         base_q12 = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_angle_error_cases();
        send_sample(0, 0, 0, 0);
        send_sample(0, 1, 0, 0);
        send_sample(0, 2, 0, 0);
        send_sample(0, -32768, 0, 0);     // |min| saturates to 15 bits
        send_sample(0, 32767, 0, 0);
        send_sample(0, 25736, 0, 1);      // exactly pi when hanging
        send_sample(0, -25736, 0, 1);
        send_sample(0, 25735, 0, 1);
        send_sample(0, 30000, 0, 1);      // past pi clamps to zero
        send_sample(0, -32768, 0, 1);
        send_sample(0, 0, 0, 1);
        drain();
    endtask

    task automatic test_position_error_cases();
        send_sample(32767, 0, -32768, 0); // widest error, 65535
        send_sample(-32768, 0, 32767, 1);
        send_sample(-32768, 0, -32768, 0);
        send_sample(1, 0, 0, 0);
        drain();
    endtask

    task automatic test_register_cases();
        write_reg(REG_ANGLE_DEAD_BAND, 16'hFFFF);  // top bit dropped
        write_reg(REG_POSITION_DEAD_BAND, 16'hFFFF);
        send_sample(32767, -32768, -32768, 0);
        send_sample(-32768, 1, 32767, 1);
        drain();
        write_reg(REG_ANGLE_DEAD_BAND, 16'd0);
        write_reg(REG_POSITION_DEAD_BAND, 16'd0);
        write_reg(REG_RATIO_BASE, 16'd0);           // base below one fires always
        send_sample(5, 7, 0, 0);
        send_sample(5, 7, 0, 0);
        drain();
        write_reg(REG_RATIO_BASE, 16'd4095);
        send_sample(6, 8, 0, 0);
        drain();
        write_reg(REG_RATIO_BASE, 16'd4096);        // 1.0
        send_sample(6, 8, 0, 0);
        drain();
        write_reg(REG_RATIO_BASE, 16'hFFFF);
        send_sample(3000, 4000, 0, 0);
        drain();
        write_reg(REG_UNMAPPED, 16'd4096);          // must not touch the base
        send_sample(3001, 4001, 0, 0);
        drain();
    endtask

    // mostly walks near the last sample so the ratio tests sit on both sides
    task automatic random_samples(input int count);
        int pos;
        int ang;
        int tgt;
        int pick;
        repeat (count) begin
            pick = $urandom_range(2);
            if (pick == 0) begin
                pos = $urandom;
                ang = $urandom;
                tgt = $urandom;
            end else if (pick == 1) begin
                pos = $signed(last_pos) + $signed($urandom_range(1000)) - 500;
                ang = $signed(last_ang) + $signed($urandom_range(1000)) - 500;
                tgt = $signed(last_tgt) + $signed($urandom_range(200)) - 100;
            end else begin
                pos = $signed($urandom_range(600)) - 300;
                ang = $signed($urandom_range(600)) - 300;
                tgt = $signed($urandom_range(600)) - 300;
            end
            send_sample(pos, ang, tgt, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input logic [15:0] a_band, input logic [15:0] p_band,
                             input logic [15:0] base);
        write_reg(REG_ANGLE_DEAD_BAND, a_band);
        write_reg(REG_POSITION_DEAD_BAND, p_band);
        write_reg(REG_RATIO_BASE, base);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        random_samples(count);
        drain();
    endtask

    task automatic test_random_traffic();
        run_phase(150, 0, 0, 16'd0, 16'd0, BaseReset);
        run_phase(150, 85, 0, 16'd100, 16'd200, 16'hFFFF);
        run_phase(150, 0, 85, 16'd2000, 16'd4000, 16'd4096);
        run_phase(150, 35, 35, 16'($urandom_range(400)), 16'($urandom_range(400)),
                  16'($urandom_range(20000, 4097)));
        run_phase(150, 35, 35, 16'h7FFF, 16'hFFFF, 16'd5000);
        run_phase(150, 0, 0, 16'($urandom_range(100)), 16'($urandom_range(100)),
                  16'($urandom_range(12000)));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_angle_error_cases();
        test_position_error_cases();
        test_register_cases();
        test_random_traffic();
        repeat (10) @(posedge i_clk);
        if (pending_flags.size() != 0) begin
            $error("%0d results never arrived", pending_flags.size());
            errors++;
        end
        $display("%0d samples sent under mixed idle/stall traffic, %0d results checked",
                 samples_sent, results_seen);
        $display("angle axis fired %0d times, position axis %0d times",
                 angle_fires, position_fires);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
